>>> rtl/gregorian_date_decrement_top_assert.svh
// Assertion macros shared by the date decrement RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef GREGORIAN_DATE_DECREMENT_TOP_ASSERT_SVH
`define GREGORIAN_DATE_DECREMENT_TOP_ASSERT_SVH

// same-cycle implication
`define GDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdd assertion failed");

// next-cycle implication
`define GDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdd assertion failed");

`endif

>>> rtl/gdd_pkg.sv
// Shared types, constants and calendar helpers for the date decrement block.
// No dependencies; used by gdd_ctrl, gdd_dp and the top level.
package gdd_pkg;

  localparam int AMOUNT_BITS_DEF = 10;

  localparam int YEAR_BITS    = 16;
  localparam int REM_BITS     = 17;
  localparam int MOD_YEARS    = 400;
  // multiple of 400 that lifts any 16-bit signed year to a non-negative value
  localparam int REM_OFFSET   = 32800;
  localparam int RED_STEPS    = 8;
  localparam int RED_IDX_BITS = 3;

  typedef enum logic [2:0] {
    KIND_DAY        = 3'd0,
    KIND_WEEK       = 3'd1,
    KIND_MONTH      = 3'd2,
    KIND_YEAR       = 3'd3,
    KIND_DECADE     = 3'd4,
    KIND_CENTURY    = 3'd5,
    KIND_MILLENNIUM = 3'd6,
    KIND_NONE       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                    load;
    logic                    reduce;
    logic [RED_IDX_BITS-1:0] red_idx;
    logic                    step;
    logic                    emit;
  } cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic out_free;
  } sts_t;

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/gdd_ctrl.sv
// Sequencer for the date decrement: load, year-mod-400 reduction, step loop, emit.
// Depends on gdd_pkg; drives gdd_dp through cmd_t and reads sts_t.
`include "gregorian_date_decrement_top_assert.svh"

module gdd_ctrl
  import gdd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t                  state_r, state_nxt;
  logic [RED_IDX_BITS-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.red_idx = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          idx_nxt   = RED_IDX_BITS'(RED_STEPS - 1);
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.reduce = 1'b1;
        if (idx_r == '0) begin
          state_nxt = ST_RUN;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_RUN: begin
        if (sts.steps_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `GDD_ASSERT_NEXT(a_load_enters_prep, cmd.load, state_r == ST_PREP)
  `GDD_ASSERT_NOW(a_step_only_in_run, cmd.step, state_r == ST_RUN && !sts.steps_zero)
  `GDD_ASSERT_NEXT(a_emit_returns_idle, cmd.emit, state_r == ST_IDLE)

endmodule

>>> rtl/gdd_dp.sv
// Datapath for the date decrement: date registers, step counter, year-mod-400
// tracker and the output register. Depends on gdd_pkg; driven by gdd_ctrl.
`include "gregorian_date_decrement_top_assert.svh"

module gdd_dp
  import gdd_pkg::*;
#(
  parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic [2:0]                   kind,
  input  logic [AMOUNT_BITS-1:0]       amount,
  input  logic [4:0]                   start_day,
  input  logic [3:0]                   start_month,
  input  logic signed [YEAR_BITS-1:0]  start_year,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [4:0]                   result_day,
  output logic [3:0]                   result_month,
  output logic signed [YEAR_BITS-1:0]  result_year,
  output logic                         year_underflow
);

  // unsaturated year: start year minus up to amount * 1000
  localparam int YW = AMOUNT_BITS + 18;
  // step counter holds up to 7 * amount
  localparam int CW = AMOUNT_BITS + 3;

  localparam logic signed [YW-1:0] YEAR_LOW = YW'(-32768);

  logic [4:0]          day_r, day_nxt;
  logic [3:0]          mon_r, mon_nxt;
  logic signed [YW-1:0] year_r, year_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                month_mode_r, month_mode_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [4:0]          out_day_r, out_day_nxt;
  logic [3:0]          out_mon_r, out_mon_nxt;
  logic [YEAR_BITS-1:0] out_year_r, out_year_nxt;
  logic                out_flag_r, out_flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r        <= day_nxt;
    mon_r        <= mon_nxt;
    year_r       <= year_nxt;
    rem_r        <= rem_nxt;
    month_mode_r <= month_mode_nxt;
    out_day_r    <= out_day_nxt;
    out_mon_r    <= out_mon_nxt;
    out_year_r   <= out_year_nxt;
    out_flag_r   <= out_flag_nxt;
  end

  logic                leap;
  logic [REM_BITS-1:0] rem_dec;
  logic [REM_BITS-1:0] red_sub;
  logic [3:0]          mon_prev;
  logic [4:0]          len_prev;
  logic signed [YW-1:0] year_mult;
  logic                underflow;

  always_comb begin
    // rem_r is the floored year mod 400 once the reduction has run
    leap = ((year_r[1:0] == 2'd0) && rem_r != REM_BITS'(100) && rem_r != REM_BITS'(200)
            && rem_r != REM_BITS'(300)) || rem_r == '0;
    rem_dec  = (rem_r == '0) ? REM_BITS'(MOD_YEARS - 1) : rem_r - 1'b1;
    red_sub  = REM_BITS'(MOD_YEARS) << cmd.red_idx;
    mon_prev = mon_r - 1'b1;
    len_prev = month_days(mon_prev, leap);

    unique case (kind_t'(kind))
      KIND_DECADE:     year_mult = YW'(10);
      KIND_CENTURY:    year_mult = YW'(100);
      KIND_MILLENNIUM: year_mult = YW'(1000);
      default:         year_mult = YW'(1);
    endcase

    underflow = year_r < YEAR_LOW;

    day_nxt        = day_r;
    mon_nxt        = mon_r;
    year_nxt       = year_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    month_mode_nxt = month_mode_r;

    priority if (cmd.load) begin
      day_nxt  = (start_day == 5'd0) ? 5'd1 : start_day;
      mon_nxt  = (start_month == 4'd0) ? 4'd1 :
                 (start_month > 4'd12) ? 4'd12 : start_month;
      year_nxt = YW'(start_year);
      rem_nxt  = REM_BITS'(start_year) + REM_BITS'(REM_OFFSET);
      month_mode_nxt = (kind_t'(kind) == KIND_MONTH);
      unique case (kind_t'(kind))
        KIND_DAY, KIND_MONTH: cnt_nxt = CW'(amount);
        KIND_WEEK:            cnt_nxt = CW'(amount) * CW'(7);
        KIND_YEAR, KIND_DECADE, KIND_CENTURY, KIND_MILLENNIUM: begin
          cnt_nxt  = '0;
          year_nxt = YW'(start_year) - YW'(amount) * year_mult;
        end
        default:              cnt_nxt = '0;
      endcase
    end else if (cmd.reduce) begin
      if (rem_r >= red_sub) begin
        rem_nxt = rem_r - red_sub;
      end
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - 1'b1;
      if (month_mode_r) begin
        if (mon_r == 4'd1) begin
          mon_nxt  = 4'd12;
          year_nxt = year_r - 1'b1;
          rem_nxt  = rem_dec;
        end else begin
          mon_nxt = mon_prev;
          // clamp to the new month, which keeps the current year
          if (day_r > len_prev) begin
            day_nxt = len_prev;
          end
        end
      end else begin
        if (day_r > 5'd1) begin
          day_nxt = day_r - 1'b1;
        end else if (mon_r == 4'd1) begin
          day_nxt  = 5'd31;
          mon_nxt  = 4'd12;
          year_nxt = year_r - 1'b1;
          rem_nxt  = rem_dec;
        end else begin
          day_nxt = len_prev;
          mon_nxt = mon_prev;
        end
      end
    end else begin
    end

    out_valid_nxt = out_valid_r && !out_tready;
    out_day_nxt   = out_day_r;
    out_mon_nxt   = out_mon_r;
    out_year_nxt  = out_year_r;
    out_flag_nxt  = out_flag_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_day_nxt   = day_r;
      out_mon_nxt   = mon_r;
      out_year_nxt  = underflow ? YEAR_BITS'(YEAR_LOW) : year_r[YEAR_BITS-1:0];
      out_flag_nxt  = underflow;
    end
  end

  assign sts.steps_zero = (cnt_r == '0);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid     = out_valid_r;
  assign result_day     = out_day_r;
  assign result_month   = out_mon_r;
  assign result_year    = out_year_r;
  assign year_underflow = out_flag_r;

  `GDD_ASSERT_NOW(a_step_rem_reduced, cmd.step, rem_r < REM_BITS'(MOD_YEARS))
  `GDD_ASSERT_NOW(a_step_month_valid, cmd.step, mon_r >= 4'd1 && mon_r <= 4'd12)
  `GDD_ASSERT_NEXT(a_emit_shows_result, cmd.emit, out_valid_r)

endmodule

>>> rtl/gregorian_date_decrement_top.sv
// Gregorian date decrement: one result per accepted date, unit and amount.
// An input transfer loads the date registers, then the start year is reduced mod 400
// and the step loop runs N day or month steps (amount, 7 * amount, or 0 for year
// units), moving one day or month per cycle; the result is emitted once the output
// register is free, and a new item is accepted only after that. Synchronous active-low reset clears the
// controller and the output valid; no item is held across reset.
module gregorian_date_decrement_top
  import gdd_pkg::*;
#(
  parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
  localparam int IN_BITS    = AMOUNT_BITS + 25,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // amount, start_day[4:0], start_month[3:0], start_year[15:0], zero pad
  input  logic [IN_W-1:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]      in_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  // result_day[4:0], result_month[3:0], result_year[15:0], zero pad
  output logic [31:0]     out_tdata,
  // year_underflow
  output logic            out_tuser
);

  cmd_t cmd;
  sts_t sts;

  logic [4:0]                  res_day;
  logic [3:0]                  res_mon;
  logic signed [YEAR_BITS-1:0] res_year;

  gdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdd_dp #(
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (in_tuser),
    .amount         (in_tdata[AMOUNT_BITS-1:0]),
    .start_day      (in_tdata[AMOUNT_BITS+4:AMOUNT_BITS]),
    .start_month    (in_tdata[AMOUNT_BITS+8:AMOUNT_BITS+5]),
    .start_year     (in_tdata[AMOUNT_BITS+24:AMOUNT_BITS+9]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .result_day     (res_day),
    .result_month   (res_mon),
    .result_year    (res_year),
    .year_underflow (out_tuser)
  );

  assign out_tdata = {7'd0, res_year, res_mon, res_day};

endmodule

>>> sim/gdd_checker.sv
// Checker for the date decrement block: watches both stream channels,
// predicts each result and compares it field by field. Uses gdd_pkg only.
`timescale 1ns / 1ps

module gdd_checker
  import gdd_pkg::*;
#(
  parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
  localparam int IN_BITS    = AMOUNT_BITS + 25,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic [2:0]      in_tuser,
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [31:0]     out_tdata,
  input  logic            out_tuser,
  output int              fail_count,
  output int              pending,
  output int              checked
);

  localparam int YEAR_FLOOR = -32768;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        underflow;
  } date_result_t;

  date_result_t due_dates[$];
  int mismatches = 0;
  int compared   = 0;

  function automatic int month_length(int m, int y);
    bit leap_year;
    leap_year = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:           return leap_year ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Walk back day by day or month by month, or subtract whole years, on an unsaturated year.
  function automatic date_result_t earlier_date(kind_t kind, logic [AMOUNT_BITS-1:0] amount,
                                                logic [4:0] sday, logic [3:0] smonth,
                                                logic [15:0] syear);
    date_result_t r;
    int d, m, y, amt;
    int steps;
    d   = int'(sday);
    m   = int'(smonth);
    y   = int'($signed(syear));
    amt = int'(amount);
    r.underflow = 1'b0;
    if (d == 0) d = 1;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    case (kind)
      KIND_DAY, KIND_WEEK: begin
        steps = (kind == KIND_WEEK) ? amt * 7 : amt;
        for (int i = 0; i < steps; i++) begin
          if (d > 1) begin
            d--;
          end else if (m == 1) begin
            m = 12;
            d = 31;
            y--;
          end else begin
            m--;
            d = month_length(m, y);
          end
        end
      end
      KIND_MONTH: begin
        for (int i = 0; i < amt; i++) begin
          if (m == 1) begin
            m = 12;
            y--;
          end else begin
            m--;
          end
          if (d > month_length(m, y)) d = month_length(m, y);
        end
      end
      KIND_YEAR:       y -= amt;
      KIND_DECADE:     y -= amt * 10;
      KIND_CENTURY:    y -= amt * 100;
      KIND_MILLENNIUM: y -= amt * 1000;
      default: ;
    endcase
    if (y < YEAR_FLOOR) begin
      y = YEAR_FLOOR;
      r.underflow = 1'b1;
    end
    r.day   = d[4:0];
    r.month = m[3:0];
    r.year  = y[15:0];
    return r;
  endfunction

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    date_result_t got;
    date_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        due_dates.push_back(earlier_date(kind_t'(in_tuser), in_tdata[AMOUNT_BITS-1:0],
                                         in_tdata[AMOUNT_BITS +: 5],
                                         in_tdata[AMOUNT_BITS+5 +: 4],
                                         in_tdata[AMOUNT_BITS+9 +: 16]));
      if (out_tvalid && out_tready) begin
        got.day       = out_tdata[4:0];
        got.month     = out_tdata[8:5];
        got.year      = out_tdata[24:9];
        got.underflow = out_tuser;
        if (due_dates.size() == 0) begin
          $error("unexpected result transfer: day %0d month %0d year %0d",
                 got.day, got.month, $signed(got.year));
          mismatches++;
        end else begin
          want = due_dates.pop_front();
          check_field("result_day", int'(want.day), int'(got.day));
          check_field("result_month", int'(want.month), int'(got.month));
          check_field("result_year", int'($signed(want.year)), int'($signed(got.year)));
          check_field("year_underflow", int'(want.underflow), int'(got.underflow));
          compared++;
        end
      end
    end
    fail_count <= mismatches;
    pending    <= due_dates.size();
    checked    <= compared;
  end

endmodule

>>> sim/tb_gregorian_date_decrement_top.sv
// Testbench top for gregorian_date_decrement_top: drives directed and random
// date requests with random idling and gives the verdict. Needs gdd_checker.
`timescale 1ns / 1ps

module tb_gregorian_date_decrement_top;
  import gdd_pkg::*;

  localparam int AMOUNT_BITS = AMOUNT_BITS_DEF;
  localparam int IN_W        = ((AMOUNT_BITS + 25 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 75;

  typedef struct {
    kind_t                  kind;
    logic [AMOUNT_BITS-1:0] amount;
    logic [4:0]             day;
    logic [3:0]             month;
    logic [15:0]            year;
  } date_request_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [2:0]      in_tuser = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [31:0]     out_tdata;
  logic            out_tuser;

  int fail_count;
  int pending;
  int checked;

  date_request_t date_requests[$];
  int sent_count  = 0;
  int cycle_count = 0;
  int cycle_limit = 1000000;
  int budget      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gregorian_date_decrement_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  gdd_checker #(.AMOUNT_BITS(AMOUNT_BITS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Queue one request and add its worst-case cycles to the run budget.
  task automatic add_request(kind_t kind, int amount, int day, int month, int year);
    date_request_t r;
    int steps;
    r.kind   = kind;
    r.amount = amount[AMOUNT_BITS-1:0];
    r.day    = day[4:0];
    r.month  = month[3:0];
    r.year   = year[15:0];
    case (kind)
      KIND_DAY, KIND_MONTH: steps = int'(r.amount);
      KIND_WEEK:            steps = 7 * int'(r.amount);
      default:              steps = 0;
    endcase
    budget += steps + 12 + 60;
    date_requests.push_back(r);
  endtask

  // Input driver: hold an item until its transfer, idle at random outside the quiet stretch.
  always @(posedge clk) begin : drive
    date_request_t nxt;
    bit busy_window;
    busy_window = (sent_count < 45) || (sent_count >= 85);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (date_requests.size() != 0 && !(busy_window && $urandom_range(0, 99) < 25)) begin
        nxt = date_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_W'({nxt.year, nxt.month, nxt.day, nxt.amount});
        in_tuser  <= nxt.kind;
        sent_count++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: stall at random except for a quiet stretch of results.
  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else if (checked >= 40 && checked < 80)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit) begin
      $display("gregorian_date_decrement_top verification failed");
      $finish;
    end
  end

  initial begin
    int kind_sel, month, day, year, amount;
    // leap days, year borrows, clamping and the extremes of every field
    add_request(KIND_DAY, 0, 15, 6, 2024);
    add_request(KIND_DAY, 1, 1, 3, 2000);
    add_request(KIND_DAY, 1, 1, 3, 1900);
    add_request(KIND_DAY, 1, 1, 1, 0);
    add_request(KIND_DAY, 1023, 31, 12, 32767);
    add_request(KIND_WEEK, 1023, 1, 1, 0);
    add_request(KIND_WEEK, 1, 3, 3, 1600);
    add_request(KIND_MONTH, 1, 31, 3, 2001);
    add_request(KIND_MONTH, 3, 31, 5, 2000);
    add_request(KIND_MONTH, 1023, 31, 12, -32768);
    add_request(KIND_YEAR, 1023, 29, 2, -32768);
    add_request(KIND_DECADE, 1023, 10, 7, 0);
    add_request(KIND_CENTURY, 1023, 5, 5, 32767);
    add_request(KIND_MILLENNIUM, 1023, 1, 1, 32767);
    add_request(KIND_MILLENNIUM, 32, 1, 1, 32767);
    add_request(KIND_NONE, 1023, 0, 0, -1);
    add_request(KIND_DAY, 5, 0, 15, 2023);
    add_request(KIND_DAY, 2, 31, 4, 2023);
    add_request(KIND_MONTH, 1, 31, 13, 2023);
    add_request(KIND_YEAR, 4, 31, 2, 2020);
    add_request(KIND_DAY, 1, 1, 1, -32768);
    add_request(KIND_MONTH, 0, 31, 4, 100);
    add_request(KIND_DAY, 366, 1, 1, 2001);
    add_request(KIND_YEAR, 0, 1, 1, 16'h5555);
    add_request(KIND_WEEK, 0, 31, 12, -21846);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 85) begin
        kind_sel = $urandom_range(0, 6);
        month    = $urandom_range(1, 12);
        day      = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
      end else begin
        kind_sel = $urandom_range(0, 7);
        month    = $urandom_range(0, 15);
        day      = $urandom_range(0, 31);
      end
      case ($urandom_range(0, 3))
        0:       year = $signed(16'($urandom()));
        1:       year = -32768 + $urandom_range(0, 2000);
        default: year = $urandom_range(1500, 2500);
      endcase
      // stepping units take one step per cycle: keep most amounts short
      if (kind_sel <= 2 && $urandom_range(0, 11) != 0)
        amount = $urandom_range(0, 60);
      else
        amount = $urandom_range(0, 1023);
      add_request(kind_t'(kind_sel), amount, day, month, year);
    end
    cycle_limit = 4 * budget + 2000;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the driver and checker updates have settled
    do @(negedge clk);
    while (date_requests.size() != 0 || in_tvalid || pending != 0);
    repeat (30) @(posedge clk);

    $display("Covered %0d date requests over all unit codes, leap years and year saturation;",
             sent_count);
    $display("%0d results compared against the predicted earlier dates.", checked);
    if (fail_count == 0)
      $display("gregorian_date_decrement_top verification clean");
    else
      $display("gregorian_date_decrement_top verification failed");
    $finish;
  end

endmodule
